>>> hw/rtl/vpom_pkg.sv
// Shared constants and types for the video plane overlay mixer.
`default_nettype none
package vpom_pkg;

   localparam int unsigned COMP_W   = 8;
   localparam int unsigned ICF_W    = 6;
   localparam int unsigned CODE_W   = 4;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned NUM_COMP = 6;

   localparam logic [COMP_W-1:0] OFFSET_LEVEL = 8'd16;

   localparam logic [COMP_W-1:0] FULL_LEVEL_RST  = 8'd255;
   localparam logic [COMP_W-1:0] HALF_LEVEL_RST  = 8'd128;
   localparam logic [COMP_W-1:0] BLACK_LEVEL_RST = 8'd16;

   // floor(m / 63) == (m * RECIP_63) >> RECIP_SHIFT for m < 17772
   localparam logic [14:0] RECIP_63   = 15'd16645;
   localparam int unsigned RECIP_SHIFT = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIX_ENABLE    = 3'd0,
      CSR_B_IN_FRONT    = 3'd1,
      CSR_BACKDROP_CODE = 3'd2,
      CSR_FULL_LEVEL    = 3'd3,
      CSR_HALF_LEVEL    = 3'd4,
      CSR_BLACK_LEVEL   = 3'd5
   } csr_index_type;

endpackage
`default_nettype wire

>>> hw/rtl/vpom_if.sv
// Channel interfaces: pixel pair input, pixel output and register write.
`default_nettype none
interface vpom_req_if import vpom_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COMP_W-1:0] a_red;
   logic [COMP_W-1:0] a_green;
   logic [COMP_W-1:0] a_blue;
   logic              a_visible;
   logic [COMP_W-1:0] b_red;
   logic [COMP_W-1:0] b_green;
   logic [COMP_W-1:0] b_blue;
   logic              b_visible;
   logic [ICF_W-1:0]  icf_a;
   logic [ICF_W-1:0]  icf_b;

   modport source (output valid, a_red, a_green, a_blue, a_visible,
                   b_red, b_green, b_blue, b_visible, icf_a, icf_b,
                   input ready);
   modport sink   (input valid, a_red, a_green, a_blue, a_visible,
                   b_red, b_green, b_blue, b_visible, icf_a, icf_b,
                   output ready);
endinterface

interface vpom_rsp_if import vpom_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COMP_W-1:0] out_red;
   logic [COMP_W-1:0] out_green;
   logic [COMP_W-1:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface vpom_csr_if import vpom_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COMP_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/video_plane_overlay_mix.sv
// Top level: two-plane contribution scaling followed by mix or overlay.
//
//   channel   dir  handshake       payload
//   req_chan  in   valid / ready   plane A and B pixels, visible flags, icf_a, icf_b
//   rsp_chan  out  valid / ready   out_red, out_green, out_blue
//   csr_chan  in   valid / ready   index, data (ready always high)
//
// One item per cycle while the output is not stalled.
// Stages: icf multiply, reciprocal multiply for /63, offset restore, mix/overlay.
// Each stage holds only when its successor is full and stalled, so bubbles
// are squeezed out and input is taken while a result waits.
// Reset (synchronous) clears stage valids and loads register defaults.
`default_nettype none
module video_plane_overlay_mix import vpom_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   vpom_req_if.sink    req_chan,
   vpom_rsp_if.source  rsp_chan,
   vpom_csr_if.sink    csr_chan
);

   // configuration registers
   logic              mix_enable_ff;
   logic              b_in_front_ff;
   logic [CODE_W-1:0] backdrop_code_ff;
   logic [COMP_W-1:0] full_level_ff;
   logic [COMP_W-1:0] half_level_ff;
   logic [COMP_W-1:0] black_level_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_enable_ff    <= 1'b0;
         b_in_front_ff    <= 1'b0;
         backdrop_code_ff <= '0;
         full_level_ff    <= FULL_LEVEL_RST;
         half_level_ff    <= HALF_LEVEL_RST;
         black_level_ff   <= BLACK_LEVEL_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_MIX_ENABLE:    mix_enable_ff    <= csr_chan.data[0];
            CSR_B_IN_FRONT:    b_in_front_ff    <= csr_chan.data[0];
            CSR_BACKDROP_CODE: backdrop_code_ff <= csr_chan.data[CODE_W-1:0];
            CSR_FULL_LEVEL:    full_level_ff    <= csr_chan.data;
            CSR_HALF_LEVEL:    half_level_ff    <= csr_chan.data;
            CSR_BLACK_LEVEL:   black_level_ff   <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // stage enables
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   assign en4 = !v4_ff || rsp_chan.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // components 0..2 plane A rgb, 3..5 plane B rgb
   logic [COMP_W-1:0] comp_in [NUM_COMP];
   logic [ICF_W-1:0]  icf_in  [NUM_COMP];

   always_comb begin
      comp_in[0] = req_chan.a_red;
      comp_in[1] = req_chan.a_green;
      comp_in[2] = req_chan.a_blue;
      comp_in[3] = req_chan.b_red;
      comp_in[4] = req_chan.b_green;
      comp_in[5] = req_chan.b_blue;
      for (int k = 0; k < NUM_COMP; k++) begin
         icf_in[k] = (k < 3) ? req_chan.icf_a : req_chan.icf_b;
      end
   end

   // stage 1: icf * (c - 16)
   logic signed [14:0] prod_in  [NUM_COMP];
   logic signed [14:0] prod_ff  [NUM_COMP];
   logic [1:0]         vis1_ff, vis2_ff, vis3_ff;

   always_comb begin
      logic signed [8:0]  diff;
      logic signed [6:0]  fac;
      logic signed [15:0] full;
      for (int k = 0; k < NUM_COMP; k++) begin
         diff = $signed({1'b0, comp_in[k]}) - $signed({1'b0, OFFSET_LEVEL});
         fac  = $signed({1'b0, icf_in[k]});
         full = diff * fac;
         prod_in[k] = full[14:0];
      end
   end

   // stage 2: magnitude / 63 by reciprocal multiply
   logic [COMP_W-1:0] quot_in  [NUM_COMP];
   logic [COMP_W-1:0] quot_ff  [NUM_COMP];
   logic [NUM_COMP-1:0] neg_in, neg_ff;

   always_comb begin
      logic [13:0] mag;
      logic [28:0] rp;
      for (int k = 0; k < NUM_COMP; k++) begin
         neg_in[k] = prod_ff[k][14];
         mag = neg_in[k] ? 14'(-prod_ff[k]) : prod_ff[k][13:0];
         rp  = 29'(mag) * 29'(RECIP_63);
         quot_in[k] = rp[RECIP_SHIFT +: COMP_W];
      end
   end

   // stage 3: restore offset
   logic [COMP_W-1:0] scl_in [NUM_COMP];
   logic [COMP_W-1:0] scl_ff [NUM_COMP];

   always_comb begin
      for (int k = 0; k < NUM_COMP; k++) begin
         scl_in[k] = neg_ff[k] ? (OFFSET_LEVEL - quot_ff[k])
                               : (OFFSET_LEVEL + quot_ff[k]);
      end
   end

   // stage 4: mix or overlay
   logic [COMP_W-1:0] out_in [3];
   logic [COMP_W-1:0] out_ff [3];

   always_comb begin
      logic              vf, vb;
      logic [COMP_W-1:0] fc, bc, lvl;
      logic [9:0]        sum;
      vf  = b_in_front_ff ? vis3_ff[1] : vis3_ff[0];
      vb  = b_in_front_ff ? vis3_ff[0] : vis3_ff[1];
      lvl = backdrop_code_ff[3] ? full_level_ff : half_level_ff;
      for (int k = 0; k < 3; k++) begin
         fc = b_in_front_ff ? scl_ff[k+3] : scl_ff[k];
         bc = b_in_front_ff ? scl_ff[k]   : scl_ff[k+3];
         sum = 10'(vf ? fc : black_level_ff) + 10'(vb ? bc : black_level_ff);
         priority if (mix_enable_ff) begin
            if (sum < 10'(OFFSET_LEVEL))
               out_in[k] = '0;
            else if (sum > 10'd271)
               out_in[k] = 8'd255;
            else
               out_in[k] = 8'(sum - 10'(OFFSET_LEVEL));
         end else if (vf) begin
            out_in[k] = fc;
         end else if (vb) begin
            out_in[k] = bc;
         end else begin
            out_in[k] = backdrop_code_ff[2-k] ? lvl : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         prod_ff <= prod_in;
         vis1_ff <= {req_chan.b_visible, req_chan.a_visible};
      end
      if (en2) begin
         quot_ff <= quot_in;
         neg_ff  <= neg_in;
         vis2_ff <= vis1_ff;
      end
      if (en3) begin
         scl_ff  <= scl_in;
         vis3_ff <= vis2_ff;
      end
      if (en4) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid     = v4_ff;
   assign rsp_chan.out_red   = out_ff[0];
   assign rsp_chan.out_green = out_ff[1];
   assign rsp_chan.out_blue  = out_ff[2];

endmodule
`default_nettype wire
